/* rtl/core/dma4c_pkg.sv */
// Shared types, codes and helper functions of the four-channel DMA core.
`default_nettype none
package dma4c_pkg;

    // Request opcodes carried on the input tuser.
    localparam logic [2:0] OP_REG_WR  = 3'd0;
    localparam logic [2:0] OP_REG_RD  = 3'd1;
    localparam logic [2:0] OP_TRIGGER = 3'd2;
    localparam logic [2:0] OP_STEP    = 3'd3;
    localparam logic [2:0] OP_RD_RET  = 3'd4;
    localparam logic [2:0] OP_STOP_VID = 3'd5;

    // Trigger occasions.
    localparam logic [2:0] OCC_HBLANK = 3'd0;
    localparam logic [2:0] OCC_VBLANK = 3'd1;
    localparam logic [2:0] OCC_VIDEO  = 3'd2;
    localparam logic [2:0] OCC_FIFO_A = 3'd3;
    localparam logic [2:0] OCC_FIFO_B = 3'd4;

    // Result kinds carried on the output tuser.
    localparam logic [1:0] KIND_REG_BYTE = 2'd0;
    localparam logic [1:0] KIND_RD_REQ   = 2'd1;
    localparam logic [1:0] KIND_WRITE    = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FIFO_A    = 3'd0;
    localparam logic [2:0] CFG_FIFO_B    = 3'd1;
    localparam logic [2:0] CFG_SRC_OK0   = 3'd2;
    localparam logic [2:0] CFG_SRC_OKX   = 3'd3;
    localparam logic [2:0] CFG_DST_OKLO  = 3'd4;
    localparam logic [2:0] CFG_DST_OK3   = 3'd5;

    // Timing modes.
    localparam logic [1:0] TM_NOW     = 2'd0;
    localparam logic [1:0] TM_VBLANK  = 2'd1;
    localparam logic [1:0] TM_HBLANK  = 2'd2;
    localparam logic [1:0] TM_SPECIAL = 2'd3;

    // Address control codes.
    localparam logic [1:0] AC_INC    = 2'd0;
    localparam logic [1:0] AC_DEC    = 2'd1;
    localparam logic [1:0] AC_FIXED  = 2'd2;
    localparam logic [1:0] AC_RELOAD = 2'd3;

    // Register offsets.
    localparam logic [3:0] OFF_LEN_LO  = 4'd8;
    localparam logic [3:0] OFF_LEN_HI  = 4'd9;
    localparam logic [3:0] OFF_CTRL_LO = 4'd10;
    localparam logic [3:0] OFF_CTRL_HI = 4'd11;

    localparam logic [1:0] CH_VIDEO = 2'd3;
    localparam logic [2:0] NO_CHANNEL = 3'd4;

    // Control image keeps control bits 15..5; field view of that image.
    typedef struct packed {
        logic       enable;
        logic       irq;
        logic [1:0] timing;
        logic       gamepak;
        logic       size;
        logic       repeat_en;
        logic [1:0] src_ctl;
        logic [1:0] dst_ctl;
    } t_ctrl;

    function automatic logic [31:0] f_step(input logic size, input logic [1:0] ctl);
        logic [31:0] mag;
        mag = size ? 32'd4 : 32'd2;
        case (ctl)
            AC_DEC:   f_step = 32'd0 - mag;
            AC_FIXED: f_step = 32'd0;
            default:  f_step = mag;
        endcase
    endfunction

    function automatic logic [16:0] f_reload(input logic [15:0] len, input logic ch3);
        logic [16:0] l;
        l = ch3 ? {1'b0, len} : {3'b000, len[13:0]};
        if (l == 17'd0) begin
            f_reload = ch3 ? 17'h10000 : 17'h04000;
        end else begin
            f_reload = l;
        end
    endfunction

    function automatic logic f_page_ok(input logic [15:0] mask, input logic [3:0] page);
        f_page_ok = mask[page];
    endfunction

endpackage
`default_nettype wire

/* rtl/core/four_channel_dma_controller_core.sv */
// A request's result goes to the output register, which frees as it is taken.
// Throughput: one request per cycle while that register is not stalled.
// All per-request work is one pass of logic from state and input to state and
// output register. Reset (synchronous, active low) clears channel state, sets
// the active channel to none and loads the default configuration values.
// Configuration writes are taken every cycle.
`default_nettype none
module four_channel_dma_controller_core
    import dma4c_pkg::*;
#(
    parameter int FIFO_BURST_WORDS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [1:0] channel, [5:2] reg_offset, [13:6] write_byte, [16:14] occasion,
    // [48:17] read_data, rest zero
    input  wire logic [55:0] i_s_tdata,
    // [2:0] op
    input  wire logic [2:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [31:0] address, [63:32] data, [64] word_size, [65] sequential,
    // [67:66] active_channel, [68] irq, rest zero
    output logic [71:0]      o_m_tdata,
    // [1:0] kind
    output logic [1:0]       o_m_tuser,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int CW = $clog2(FIFO_BURST_WORDS + 1);

    // configuration
    logic [27:0] r_fifo_a, r_fifo_b;
    logic [15:0] r_src_ok0, r_src_okx, r_dst_oklo, r_dst_ok3;

    // channel state
    logic [27:0] r_src_reg [4];
    logic [27:0] r_dst_reg [4];
    logic [15:0] r_len_reg [4];
    t_ctrl       r_ctrl [4];
    logic [31:0] r_wsrc [4];
    logic [31:0] r_wdst [4];
    logic [16:0] r_wlen [4];
    logic [3:0]  r_may_read, r_hb, r_vb, r_vid, r_run;
    logic [2:0]  r_active;
    logic [31:0] r_latch;
    logic [CW-1:0] r_cnt;
    logic        r_pend, r_seq;

    logic [27:0] n_src_reg [4];
    logic [27:0] n_dst_reg [4];
    logic [15:0] n_len_reg [4];
    t_ctrl       n_ctrl [4];
    logic [31:0] n_wsrc [4];
    logic [31:0] n_wdst [4];
    logic [16:0] n_wlen [4];
    logic [3:0]  n_may_read, n_hb, n_vb, n_vid, n_run;
    logic [2:0]  n_active;
    logic [31:0] n_latch;
    logic [CW-1:0] n_cnt;
    logic        n_pend, n_seq;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_kind, n_kind;
    logic [31:0] r_addr, n_addr, r_data, n_data;
    logic        r_word, n_word, r_oseq, n_oseq, r_irq, n_irq;
    logic [1:0]  r_och, n_och;

    logic accept;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign accept      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_kind;
    assign o_m_tdata  = {3'b000, r_irq, r_och, r_oseq, r_word, r_data, r_addr};

    always_comb begin
        logic [2:0]  op;
        logic [1:0]  ch, a;
        logic [3:0]  off;
        logic [7:0]  wb, hb;
        logic [2:0]  occ;
        logic [31:0] rd, align, sh_val, sh_mask, amask;
        logic        was_on, fifo, do_write, do_complete, cur_ch3;
        logic [3:0]  bit_a, bit_c;
        logic [27:0] target;
        logic [CW-1:0] cnt_inc;
        logic [2:0]  pick;

        op  = i_s_tuser;
        ch  = i_s_tdata[1:0];
        off = i_s_tdata[5:2];
        wb  = i_s_tdata[13:6];
        occ = i_s_tdata[16:14];
        rd  = i_s_tdata[48:17];

        n_src_reg = r_src_reg;
        n_dst_reg = r_dst_reg;
        n_len_reg = r_len_reg;
        n_ctrl    = r_ctrl;
        n_wsrc    = r_wsrc;
        n_wdst    = r_wdst;
        n_wlen    = r_wlen;
        n_may_read = r_may_read;
        n_hb = r_hb; n_vb = r_vb; n_vid = r_vid; n_run = r_run;
        n_active = r_active;
        n_latch  = r_latch;
        n_cnt    = r_cnt;
        n_pend   = r_pend;
        n_seq    = r_seq;

        n_out_valid = r_out_valid && !i_m_tready;
        n_kind = r_kind; n_addr = r_addr; n_data = r_data;
        n_word = r_word; n_oseq = r_oseq; n_och = r_och; n_irq = r_irq;

        was_on = 1'b0; fifo = 1'b0; do_write = 1'b0; do_complete = 1'b0;
        a = r_active[1:0];
        bit_c = 4'b0001 << ch;
        bit_a = 4'b0001 << a;
        hb = wb; align = 32'hFFFF_FFFF; sh_val = 32'd0; sh_mask = 32'd0; amask = 32'd0;
        target = 28'd0; cnt_inc = r_cnt; pick = NO_CHANNEL; cur_ch3 = 1'b0;

        if (accept) begin
            case (op)
                OP_REG_WR: begin
                    sh_val  = {24'd0, wb} << {off[1:0], 3'b000};
                    sh_mask = 32'h0000_00FF << {off[1:0], 3'b000};
                    if (off < 4'd4) begin
                        amask = (ch == 2'd0) ? 32'h07FF_FFFF : 32'h0FFF_FFFF;
                        n_src_reg[ch] = 28'((({4'd0, r_src_reg[ch]} & ~sh_mask))
                                           | (sh_val & amask));
                    end else if (off < 4'd8) begin
                        amask = (ch == CH_VIDEO) ? 32'h0FFF_FFFF : 32'h07FF_FFFF;
                        n_dst_reg[ch] = 28'((({4'd0, r_dst_reg[ch]} & ~sh_mask))
                                           | (sh_val & amask));
                    end else if (off == OFF_LEN_LO) begin
                        n_len_reg[ch] = {r_len_reg[ch][15:8], wb};
                    end else if (off == OFF_LEN_HI) begin
                        n_len_reg[ch] = {wb, r_len_reg[ch][7:0]};
                    end else if (off == OFF_CTRL_LO) begin
                        n_ctrl[ch] = t_ctrl'({r_ctrl[ch][10:3], wb[7:5]});
                    end else if (off == OFF_CTRL_HI) begin
                        was_on = r_ctrl[ch].enable;
                        if (wb[5:4] == TM_NOW) hb[1] = 1'b0;
                        if (ch != CH_VIDEO) hb[3] = 1'b0;
                        n_ctrl[ch] = t_ctrl'({hb, r_ctrl[ch][2:0]});
                        cur_ch3 = (ch == CH_VIDEO);
                        if (n_ctrl[ch].enable) begin
                            if (n_ctrl[ch].timing == TM_HBLANK) n_hb = n_hb | bit_c;
                            else if (n_ctrl[ch].timing == TM_VBLANK) n_vb = n_vb | bit_c;
                            else if (n_ctrl[ch].timing == TM_SPECIAL && cur_ch3)
                                n_vid = n_vid | bit_c;
                            if (!was_on) begin
                                align = n_ctrl[ch].size ? 32'hFFFF_FFFC : 32'hFFFF_FFFE;
                                n_wdst[ch] = f_page_ok(cur_ch3 ? r_dst_ok3 : r_dst_oklo,
                                                       r_dst_reg[ch][27:24])
                                             ? {4'd0, r_dst_reg[ch]} : 32'd0;
                                if (f_page_ok((ch == 2'd0) ? r_src_ok0 : r_src_okx,
                                              r_src_reg[ch][27:24])) begin
                                    n_wsrc[ch] = {4'd0, r_src_reg[ch]};
                                    n_may_read[ch] = 1'b1;
                                end else begin
                                    n_may_read[ch] = 1'b0;
                                end
                                n_wsrc[ch] = n_wsrc[ch] & align;
                                n_wdst[ch] = n_wdst[ch] & align;
                                n_wlen[ch] = f_reload(r_len_reg[ch], cur_ch3);
                                if (n_ctrl[ch].timing == TM_NOW) n_run = n_run | bit_c;
                            end
                        end else begin
                            n_hb  = n_hb & ~bit_c;
                            n_vb  = n_vb & ~bit_c;
                            n_vid = n_vid & ~bit_c;
                        end
                    end
                end
                OP_REG_RD: begin
                    n_out_valid = 1'b1;
                    n_kind = KIND_REG_BYTE;
                    n_addr = 32'd0;
                    if (off == OFF_CTRL_LO) n_data = {24'd0, r_ctrl[ch][2:0], 5'd0};
                    else if (off == OFF_CTRL_HI) n_data = {24'd0, r_ctrl[ch][10:3]};
                    else n_data = 32'd0;
                    n_word = 1'b0; n_oseq = 1'b0; n_och = 2'd0; n_irq = 1'b0;
                end
                OP_TRIGGER: begin
                    if (occ == OCC_HBLANK) n_run = n_run | r_hb;
                    else if (occ == OCC_VBLANK) n_run = n_run | r_vb;
                    else if (occ == OCC_VIDEO) n_run = n_run | r_vid;
                    else if (occ == OCC_FIFO_A || occ == OCC_FIFO_B) begin
                        target = (occ == OCC_FIFO_A) ? r_fifo_a : r_fifo_b;
                        for (int c = 1; c <= 2; c++) begin
                            if (r_ctrl[c].enable && r_ctrl[c].timing == TM_SPECIAL
                                && r_dst_reg[c] == target)
                                n_run[c] = 1'b1;
                        end
                    end
                end
                OP_STEP: begin
                    // Bring the active channel up to date before the unit.
                    if (!r_pend && r_cnt == '0) begin
                        pick = NO_CHANNEL;
                        for (int c = 3; c >= 0; c--) begin
                            if (r_run[c]) pick = 3'(c);
                        end
                        if (pick != r_active) begin
                            n_active = pick;
                            n_seq = 1'b0;
                        end
                    end
                    a = n_active[1:0];
                    bit_a = 4'b0001 << a;
                    if (!n_active[2] && !r_pend) begin
                        fifo = (r_cnt != '0) || (r_ctrl[a].timing == TM_SPECIAL
                                                 && (a == 2'd1 || a == 2'd2));
                        if (fifo && r_cnt == '0) n_run = n_run & ~bit_a;
                        if (!fifo && r_wlen[a] == 17'd0) begin
                            do_complete = 1'b1;
                        end else if (r_may_read[a]) begin
                            n_out_valid = 1'b1;
                            n_kind = KIND_RD_REQ;
                            n_addr = r_wsrc[a];
                            n_data = 32'd0;
                            n_word = fifo ? 1'b1 : r_ctrl[a].size;
                            n_oseq = n_seq;
                            n_och  = a;
                            n_irq  = 1'b0;
                            n_pend = 1'b1;
                        end else begin
                            do_write = 1'b1;
                        end
                    end
                end
                OP_RD_RET: begin
                    if (r_pend && !r_active[2]) begin
                        fifo = (r_cnt != '0) || (r_ctrl[a].timing == TM_SPECIAL
                                                 && (a == 2'd1 || a == 2'd2));
                        n_latch = (fifo || r_ctrl[a].size) ? rd : {rd[15:0], rd[15:0]};
                        n_pend = 1'b0;
                        do_write = 1'b1;
                    end
                end
                OP_STOP_VID: begin
                    if (r_ctrl[CH_VIDEO].enable && r_ctrl[CH_VIDEO].timing == TM_SPECIAL) begin
                        n_ctrl[CH_VIDEO].enable = 1'b0;
                        n_run[CH_VIDEO] = 1'b0;
                        n_vid[CH_VIDEO] = 1'b0;
                        if (r_active == {1'b0, CH_VIDEO}) n_pend = 1'b0;
                    end
                end
                default: begin
                end
            endcase

            if (do_write) begin
                n_out_valid = 1'b1;
                n_kind = KIND_WRITE;
                n_addr = n_wdst[a];
                n_data = n_latch;
                n_word = fifo ? 1'b1 : r_ctrl[a].size;
                n_oseq = n_seq;
                n_och  = a;
                n_irq  = 1'b0;
                n_seq  = 1'b1;
                if (fifo) begin
                    n_wsrc[a] = n_wsrc[a] + 32'd4;
                    cnt_inc = r_cnt + 1'b1;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= CW'(FIFO_BURST_WORDS)) begin
                        n_cnt = '0;
                        if (!r_ctrl[a].repeat_en) n_ctrl[a].enable = 1'b0;
                        n_irq = r_ctrl[a].irq;
                        n_seq = 1'b0;
                    end
                end else begin
                    n_wsrc[a] = n_wsrc[a] + f_step(r_ctrl[a].size, r_ctrl[a].src_ctl);
                    n_wdst[a] = n_wdst[a] + f_step(r_ctrl[a].size, r_ctrl[a].dst_ctl);
                    n_wlen[a] = n_wlen[a] - 17'd1;
                    if (n_wlen[a] == 17'd0) begin
                        do_complete = 1'b1;
                        n_irq = r_ctrl[a].irq;
                    end
                end
            end

            if (do_complete) begin
                cur_ch3 = (a == CH_VIDEO);
                if (r_ctrl[a].repeat_en) begin
                    n_wlen[a] = f_reload(r_len_reg[a], cur_ch3);
                    if (r_ctrl[a].dst_ctl == AC_RELOAD) begin
                        align = r_ctrl[a].size ? 32'hFFFF_FFFC : 32'hFFFF_FFFE;
                        n_wdst[a] = f_page_ok(cur_ch3 ? r_dst_ok3 : r_dst_oklo,
                                              r_dst_reg[a][27:24])
                                    ? ({4'd0, r_dst_reg[a]} & align) : 32'd0;
                    end
                    n_run = n_run & ~bit_a;
                end else begin
                    n_ctrl[a].enable = 1'b0;
                    n_run = n_run & ~bit_a;
                    n_hb  = n_hb & ~bit_a;
                    n_vb  = n_vb & ~bit_a;
                    n_vid = n_vid & ~bit_a;
                end
                n_seq = 1'b0;
            end

            // Final arbitration: lowest runnable channel wins between units.
            if (!n_pend && n_cnt == '0) begin
                pick = NO_CHANNEL;
                for (int c = 3; c >= 0; c--) begin
                    if (n_run[c]) pick = 3'(c);
                end
                if (pick != n_active) begin
                    n_active = pick;
                    n_seq = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo_a   <= 28'd67109024;
            r_fifo_b   <= 28'd67109028;
            r_src_ok0  <= 16'h00FF;
            r_src_okx  <= 16'hFFFF;
            r_dst_oklo <= 16'h00FF;
            r_dst_ok3  <= 16'hFFFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FIFO_A:   r_fifo_a   <= i_cfg_data[27:0];
                CFG_FIFO_B:   r_fifo_b   <= i_cfg_data[27:0];
                CFG_SRC_OK0:  r_src_ok0  <= i_cfg_data[15:0];
                CFG_SRC_OKX:  r_src_okx  <= i_cfg_data[15:0];
                CFG_DST_OKLO: r_dst_oklo <= i_cfg_data[15:0];
                CFG_DST_OK3:  r_dst_ok3  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 4; c++) begin
                r_src_reg[c] <= '0;
                r_dst_reg[c] <= '0;
                r_len_reg[c] <= '0;
                r_ctrl[c]    <= '0;
                r_wsrc[c]    <= '0;
                r_wdst[c]    <= '0;
                r_wlen[c]    <= '0;
            end
            r_may_read  <= '0;
            r_hb        <= '0;
            r_vb        <= '0;
            r_vid       <= '0;
            r_run       <= '0;
            r_active    <= NO_CHANNEL;
            r_latch     <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_seq       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_src_reg   <= n_src_reg;
            r_dst_reg   <= n_dst_reg;
            r_len_reg   <= n_len_reg;
            r_ctrl      <= n_ctrl;
            r_wsrc      <= n_wsrc;
            r_wdst      <= n_wdst;
            r_wlen      <= n_wlen;
            r_may_read  <= n_may_read;
            r_hb        <= n_hb;
            r_vb        <= n_vb;
            r_vid       <= n_vid;
            r_run       <= n_run;
            r_active    <= n_active;
            r_latch     <= n_latch;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_addr <= n_addr;
        r_data <= n_data;
        r_word <= n_word;
        r_oseq <= n_oseq;
        r_och  <= n_och;
        r_irq  <= n_irq;
    end

endmodule
`default_nettype wire

/* rtl/core/dma4c_checker.sv */
// Port-level checker for the DMA core and its bind into the core module.
`default_nettype none
module dma4c_checker
    import dma4c_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [71:0] o_m_tdata,
    input wire logic [1:0]  o_m_tuser
);

    a_kind_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == KIND_REG_BYTE || o_m_tuser == KIND_RD_REQ
                        || o_m_tuser == KIND_WRITE))
        else $error("unknown result kind");

    a_rd_req_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_RD_REQ) |-> (o_m_tdata[63:32] == 32'd0
                                                      && !o_m_tdata[68]))
        else $error("read request carries data or interrupt");

    a_reg_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_REG_BYTE) |-> (o_m_tdata[31:0] == 32'd0
                                                        && o_m_tdata[63:40] == 24'd0))
        else $error("register byte result has stray bits");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind four_channel_dma_controller_core dma4c_checker u_dma4c_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
